FILE: src/ppa_pkg.sv
// ----------------------------------------------------------------------------
// ppa_pkg
// Shared types for the patience pile assigner: controller commands and
// datapath status.
// ----------------------------------------------------------------------------
package ppa_pkg;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the incoming transaction and open the search
    logic step;    // run one binary search step
    logic commit;  // write the tail, update the count, load the result
  } ppa_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic start_empty;  // no piles to search for the incoming value
    logic step_done;    // this search step closes the range
  } ppa_sts_t;

endpackage

FILE: src/ppa_ctrl.sv
// ----------------------------------------------------------------------------
// ppa_ctrl
// Controller: sequences load, binary search and commit of one transaction,
// and owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module ppa_ctrl
  import ppa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  ppa_sts_t sts,
  output ppa_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_tvalid_r;
  logic       out_tvalid_nxt;
  logic       slot_free;

  assign slot_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.start_empty ? S_FINISH : S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.step = 1'b1;
        if (sts.step_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd.commit) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

endmodule

FILE: src/ppa_dpath.sv
// ----------------------------------------------------------------------------
// ppa_dpath
// Datapath: pile tail memory, pile count, binary search bounds and the
// result register.
// ----------------------------------------------------------------------------
module ppa_dpath
  import ppa_pkg::*;
#(
  parameter int MAX_PILES  = 1024,
  parameter int VALUE_BITS = 32,
  parameter int IDX_W      = $clog2(MAX_PILES),
  parameter int CNT_W      = $clog2(MAX_PILES + 1)
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  ppa_cmd_t              cmd,
  output ppa_sts_t              sts,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  in_restart,
  output logic [IDX_W-1:0]      pile_index,
  output logic [CNT_W-1:0]      pile_count,
  output logic                  overflow
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PILES);

  logic [VALUE_BITS-1:0] tails_mem [MAX_PILES];
  logic [VALUE_BITS-1:0] rdata_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      lo_r;
  logic [CNT_W-1:0]      hi_r;
  logic [IDX_W-1:0]      mid_r;
  logic [IDX_W-1:0]      pile_index_r;
  logic [CNT_W-1:0]      pile_count_r;
  logic                  overflow_r;

  logic [CNT_W-1:0]      eff_count;
  logic [IDX_W-1:0]      start_mid;
  logic                  tail_less;
  logic [CNT_W-1:0]      lo_step;
  logic [CNT_W-1:0]      hi_step;
  logic [CNT_W:0]        bound_sum;
  logic [IDX_W-1:0]      mid_step;
  logic [IDX_W-1:0]      rd_addr;
  logic                  new_pile;
  logic                  full;
  logic                  wr_en;

  // Restart empties the store before this value is placed
  assign eff_count = in_restart ? '0 : count_r;
  assign start_mid = IDX_W'(eff_count >> 1);

  // One lower-bound step on the tail read at mid_r
  assign tail_less = $signed(rdata_r) < $signed(value_r);
  assign lo_step   = tail_less ? (CNT_W'(mid_r) + CNT_W'(1)) : lo_r;
  assign hi_step   = tail_less ? hi_r : CNT_W'(mid_r);
  assign bound_sum = {1'b0, lo_step} + {1'b0, hi_step};
  assign mid_step  = IDX_W'(bound_sum[CNT_W:1]);

  assign sts.start_empty = (eff_count == '0);
  assign sts.step_done   = (lo_step == hi_step);

  assign rd_addr  = cmd.load ? start_mid : mid_step;
  assign new_pile = (lo_r == count_r);
  assign full     = new_pile && (count_r == MAX_CNT);
  assign wr_en    = cmd.commit && !full;

  // Tail memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tails_mem[lo_r[IDX_W-1:0]] <= value_r;
    end
    rdata_r <= tails_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.load) begin
      count_r <= eff_count;
    end else if (wr_en && new_pile) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= in_value;
      lo_r    <= '0;
      hi_r    <= eff_count;
      mid_r   <= start_mid;
    end else if (cmd.step) begin
      lo_r    <= lo_step;
      hi_r    <= hi_step;
      mid_r   <= mid_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pile_index_r <= full ? '0 : lo_r[IDX_W-1:0];
      pile_count_r <= (new_pile && !full) ? count_r + CNT_W'(1) : count_r;
      overflow_r   <= full;
    end
  end

  assign pile_index = pile_index_r;
  assign pile_count = pile_count_r;
  assign overflow   = overflow_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("pile count exceeds store depth");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (lo_r < hi_r) && (hi_r <= count_r))
    else $error("search step on an empty or out-of-range interval");

  a_overflow_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && full |=> $stable(count_r) && overflow_r)
    else $error("dropped value changed the pile count");

endmodule

FILE: src/patience_pile_assigner.sv
// ----------------------------------------------------------------------------
// patience_pile_assigner
// Greedy patience sorting: places each signed value on a pile and reports
// the pile and the running longest strictly increasing subsequence length.
// ----------------------------------------------------------------------------
// Each input transaction carries a signed value (and a restart flag in
// in_tuser that empties all piles first). The block keeps the pile tails
// sorted in an internal memory and runs a lower-bound binary search for the
// first tail not below the value; that tail is replaced, or a new pile is
// opened when every tail is smaller. One result transaction follows every
// input: the pile index, the pile count after the item (the longest
// strictly increasing subsequence length since restart) and an overflow
// flag, set when a new pile was needed but all MAX_PILES piles are in use;
// such a value is dropped, pile index reads 0 and the count is unchanged.
// One transaction is processed at a time. With n piles open the search
// takes ceil(log2(n+1)) steps at most, one memory read and compare per
// cycle. The memory needs no clearing after reset: only entries below
// the pile count are ever read. The result register lets the next
// transaction be accepted while the previous result still waits on
// out_tready.
// ----------------------------------------------------------------------------
module patience_pile_assigner
  import ppa_pkg::*;
#(
  parameter int MAX_PILES  = 1024,
  parameter int VALUE_BITS = 32
)
(
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: value [VALUE_BITS-1:0], zero padding above
  input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // in_tuser: restart
  input  logic                                 in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // out_tdata: pile_index, pile_count, overflow, zero padding above
  output logic [(($clog2(MAX_PILES) + $clog2(MAX_PILES + 1) + 1 + 7) / 8) * 8 - 1:0]
                                               out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready
);

  localparam int IDX_W      = $clog2(MAX_PILES);
  localparam int CNT_W      = $clog2(MAX_PILES + 1);
  localparam int OUT_FLD_W  = IDX_W + CNT_W + 1;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  ppa_cmd_t         cmd;
  ppa_sts_t         sts;
  logic [IDX_W-1:0] pile_index;
  logic [CNT_W-1:0] pile_count;
  logic             overflow;

  // Sequence load, search steps and commit
  ppa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Tail store, search bounds and result register
  ppa_dpath #(
    .MAX_PILES  (MAX_PILES),
    .VALUE_BITS (VALUE_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_value   (in_tdata[VALUE_BITS-1:0]),
    .in_restart (in_tuser),
    .pile_index (pile_index),
    .pile_count (pile_count),
    .overflow   (overflow)
  );

  // Pack the result fields from the lowest bit up, pad with zeros
  assign out_tdata = OUT_DATA_W'({overflow, pile_count, pile_index});

endmodule
